@@ hw/rtl/ts_pkg.sv @@
`default_nettype none

package ts_pkg;

  // default number of thread slots, slot zero being the idle thread
  localparam int TS_MAX_THREADS = 8;

  // fixed field widths
  localparam int CFG_W    = 4;
  localparam int SLEEP_W  = 16;
  localparam int PICK_W   = 16;
  localparam int TICK_W   = 32;
  localparam int THREAD_W = 3;

  // item operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  // per-slot thread state
  typedef enum logic [1:0] {
    ST_READY    = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_SLEEPING = 2'd2
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic sweep;
    logic mod_step;
    logic search_start;
    logic search;
    logic hit;
    logic pick;
    logic load;
  } ts_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic op_sleep;
    logic sweep_done;
    logic single;
    logic mod_done;
    logic hit;
    logic exhausted;
    logic out_free;
  } ts_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/ts_intf.sv @@
`default_nettype none

// request channel: one item per scheduler event
interface ts_req_if import ts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [SLEEP_W-1:0] sleep_ticks;

  modport source (output valid, operation, sleep_ticks, input ready);
  modport sink   (input valid, operation, sleep_ticks, output ready);
endinterface

// response channel: one item per request
interface ts_rsp_if import ts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [THREAD_W-1:0] running_thread;
  logic [THREAD_W-1:0] previous_thread;
  logic                switched;
  logic [PICK_W-1:0]   picks_of_running;
  logic [TICK_W-1:0]   ticks_seen;

  modport source (output valid, running_thread, previous_thread, switched,
                  picks_of_running, ticks_seen, input ready);
  modport sink   (input valid, running_thread, previous_thread, switched,
                  picks_of_running, ticks_seen, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ts_ctrl.sv @@
`default_nettype none

module ts_ctrl import ts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  ts_sts_t sts_i,
  output ts_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_MOD,
    S_SEARCH,
    S_PICK,
    S_LOAD
  } state_e;

  state_e state_q, state_d;

  // sequencing of one item through sweep, modulo, search, pick and load
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (sts_i.op_sleep || sts_i.sweep_done) begin
          state_d = S_MOD;
        end else begin
          cmd_o.sweep = 1'b1;
        end
      end
      S_MOD: begin
        if (sts_i.single) begin
          state_d = S_PICK;
        end else if (sts_i.mod_done) begin
          cmd_o.search_start = 1'b1;
          state_d            = S_SEARCH;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.hit) begin
          cmd_o.hit = 1'b1;
          state_d   = S_PICK;
        end else if (sts_i.exhausted) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        if (sts_i.out_free) begin
          cmd_o.pick = 1'b1;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ts_dpath.sv @@
`default_nettype none

module ts_dpath import ts_pkg::*; #(
  parameter int MaxThreads = TS_MAX_THREADS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                in_operation_i,
  input  logic [SLEEP_W-1:0]  in_sleep_ticks_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [THREAD_W-1:0] out_running_thread_o,
  output logic [THREAD_W-1:0] out_previous_thread_o,
  output logic                out_switched_o,
  output logic [PICK_W-1:0]   out_picks_of_running_o,
  output logic [TICK_W-1:0]   out_ticks_seen_o,
  input  ts_cmd_t             cmd_i,
  output ts_sts_t             sts_o
);

  localparam int IdxW = (MaxThreads > 1) ? $clog2(MaxThreads) : 1;
  localparam int CntW = $clog2(MaxThreads + 1);
  localparam int CmpW = (CntW > CFG_W) ? CntW : CFG_W;

  // configuration and per-item registers
  logic [CFG_W-1:0]  thread_count_q;
  logic              op_q;
  logic [CntW-1:0]   n_q;
  logic [IdxW-1:0]   cur_q;
  logic [IdxW-1:0]   next_q;
  logic [TICK_W-1:0] tick_q;
  logic [IdxW-1:0]   r_q;
  logic [CntW-1:0]   sw_cnt_q;
  logic [CntW-1:0]   sr_cnt_q;
  logic [IdxW-1:0]   sr_id_q;

  // slot memories and their read registers
  status_e            status_mem [MaxThreads];
  logic [SLEEP_W-1:0] sleep_mem  [MaxThreads];
  logic [PICK_W-1:0]  pick_mem   [MaxThreads];
  logic [MaxThreads-1:0] status_vld_q;
  logic [MaxThreads-1:0] pick_vld_q;

  logic               rd_pend_q;
  logic [IdxW-1:0]    rd_idx_q;
  status_e            st_q;
  logic               st_vld_rd_q;
  logic [SLEEP_W-1:0] sl_q;
  logic [PICK_W-1:0]  pk_q;
  logic               pk_vld_rd_q;

  // output register
  logic                out_valid_q;
  logic [THREAD_W-1:0] out_run_q;
  logic [THREAD_W-1:0] out_prev_q;
  logic                out_sw_q;
  logic [PICK_W-1:0]   out_pick_q;
  logic [TICK_W-1:0]   out_tick_q;

  logic [CmpW-1:0]    tc_ext;
  logic [CntW-1:0]    n_now;
  logic [CntW-1:0]    span;
  logic               rd_en;
  logic [IdxW-1:0]    rd_addr;
  status_e            st_eff;
  logic [SLEEP_W-1:0] sl_dec;
  logic               sweep_proc;
  logic               st_we;
  logic [IdxW-1:0]    st_waddr;
  status_e            st_wdata;
  logic               sl_we;
  logic [IdxW-1:0]    sl_waddr;
  logic [SLEEP_W-1:0] sl_wdata;
  logic [PICK_W-1:0]  pk_eff;
  logic [PICK_W-1:0]  pk_new;
  logic               pk_we;

  // slots in use, clamped to 1..MaxThreads
  always_comb begin
    tc_ext = CmpW'(thread_count_q);
    if (tc_ext > CmpW'(MaxThreads)) begin
      n_now = CntW'(MaxThreads);
    end else if (tc_ext == '0) begin
      n_now = CntW'(1);
    end else begin
      n_now = CntW'(tc_ext);
    end
  end

  assign span = n_q - CntW'(1);

  // shared read port: sweep walks 0..n-1, search walks round robin over 1..n-1
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = sw_cnt_q[IdxW-1:0];
    if (cmd_i.sweep && (sw_cnt_q < n_q)) begin
      rd_en   = 1'b1;
      rd_addr = sw_cnt_q[IdxW-1:0];
    end else if (cmd_i.search && (sr_cnt_q < span)) begin
      rd_en   = 1'b1;
      rd_addr = sr_id_q;
    end
  end

  // never-written entries read as their reset state
  assign st_eff = st_vld_rd_q ? st_q : ((rd_idx_q == '0) ? ST_RUNNING : ST_READY);
  assign sl_dec = sl_q - SLEEP_W'(1);
  assign sweep_proc = cmd_i.sweep && rd_pend_q && (st_eff == ST_SLEEPING);

  // status write port
  always_comb begin
    st_we    = 1'b0;
    st_waddr = cur_q;
    st_wdata = ST_READY;
    if (cmd_i.accept) begin
      st_we    = 1'b1;
      st_waddr = cur_q;
      st_wdata = (in_operation_i == OP_SLEEP) ? ST_SLEEPING : ST_READY;
    end else if (sweep_proc && (sl_dec == '0)) begin
      st_we    = 1'b1;
      st_waddr = rd_idx_q;
      st_wdata = ST_READY;
    end else if (cmd_i.pick) begin
      st_we    = 1'b1;
      st_waddr = next_q;
      st_wdata = ST_RUNNING;
    end
  end

  // countdown write port; a countdown is only read while its slot sleeps
  always_comb begin
    sl_we    = 1'b0;
    sl_waddr = cur_q;
    sl_wdata = in_sleep_ticks_i;
    if (cmd_i.accept && (in_operation_i == OP_SLEEP)) begin
      sl_we    = 1'b1;
      sl_waddr = cur_q;
      sl_wdata = in_sleep_ticks_i;
    end else if (sweep_proc) begin
      sl_we    = 1'b1;
      sl_waddr = rd_idx_q;
      sl_wdata = sl_dec;
    end
  end

  // pick count update, counted on ticks only
  assign pk_eff = pk_vld_rd_q ? pk_q : '0;
  assign pk_new = (op_q == OP_SLEEP) ? pk_eff : pk_eff + PICK_W'(1);
  assign pk_we  = cmd_i.load && (op_q == OP_TICK);

  // status and countdown memories
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      status_mem[st_waddr] <= st_wdata;
    end
    if (rd_en) begin
      st_q        <= status_mem[rd_addr];
      st_vld_rd_q <= status_vld_q[rd_addr];
      rd_idx_q    <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sl_we) begin
      sleep_mem[sl_waddr] <= sl_wdata;
    end
    if (rd_en) begin
      sl_q <= sleep_mem[rd_addr];
    end
  end

  // pick count memory
  always_ff @(posedge clk_i) begin
    if (pk_we) begin
      pick_mem[next_q] <= pk_new;
    end
    if (cmd_i.pick) begin
      pk_q        <= pick_mem[next_q];
      pk_vld_rd_q <= pick_vld_q[next_q];
    end
  end

  // written-entry flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_vld_q <= '0;
      pick_vld_q   <= '0;
    end else begin
      if (st_we) begin
        status_vld_q[st_waddr] <= 1'b1;
      end
      if (pk_we) begin
        pick_vld_q[next_q] <= 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thread_count_q <= CFG_W'(1);
      op_q           <= OP_TICK;
      n_q            <= CntW'(1);
      cur_q          <= '0;
      next_q         <= '0;
      tick_q         <= '0;
      r_q            <= '0;
      sw_cnt_q       <= '0;
      sr_cnt_q       <= '0;
      sr_id_q        <= '0;
      rd_pend_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      rd_pend_q <= rd_en;
      if (cfg_we_i) begin
        thread_count_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        op_q     <= in_operation_i;
        n_q      <= n_now;
        next_q   <= '0;
        r_q      <= cur_q;
        sw_cnt_q <= '0;
        if (in_operation_i == OP_TICK) begin
          tick_q <= tick_q + TICK_W'(1);
        end
      end
      if (cmd_i.sweep && (sw_cnt_q < n_q)) begin
        sw_cnt_q <= sw_cnt_q + CntW'(1);
      end
      // start slot is one past current modulo span, by repeated subtraction
      if (cmd_i.mod_step) begin
        r_q <= IdxW'(CntW'(r_q) - span);
      end
      if (cmd_i.search_start) begin
        sr_id_q  <= IdxW'(CntW'(r_q) + CntW'(1));
        sr_cnt_q <= '0;
      end else if (cmd_i.search && (sr_cnt_q < span)) begin
        sr_cnt_q <= sr_cnt_q + CntW'(1);
        sr_id_q  <= (CntW'(sr_id_q) == span) ? IdxW'(1) : sr_id_q + IdxW'(1);
      end
      if (cmd_i.hit) begin
        next_q <= rd_idx_q;
      end
      if (cmd_i.load) begin
        cur_q       <= next_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_run_q  <= THREAD_W'(next_q);
      out_prev_q <= THREAD_W'(cur_q);
      out_sw_q   <= (next_q != cur_q);
      out_pick_q <= pk_new;
      out_tick_q <= tick_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_running_thread_o   = out_run_q;
  assign out_previous_thread_o  = out_prev_q;
  assign out_switched_o         = out_sw_q;
  assign out_picks_of_running_o = out_pick_q;
  assign out_ticks_seen_o       = out_tick_q;

  // status to controller
  always_comb begin
    sts_o            = '0;
    sts_o.op_sleep   = (op_q == OP_SLEEP);
    sts_o.sweep_done = (sw_cnt_q == n_q) && !rd_pend_q;
    sts_o.single     = (n_q < CntW'(2));
    sts_o.mod_done   = (CntW'(r_q) < span);
    sts_o.hit        = rd_pend_q && (st_eff == ST_READY);
    sts_o.exhausted  = (sr_cnt_q == span) && !rd_pend_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

`ifndef SYNTHESIS
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !out_valid_q)
    else $error("result loaded over a waiting result");

  a_next_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> ((next_q == '0) || (CntW'(next_q) < n_q)))
    else $error("picked slot outside the slots in use");

  a_tick_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && (in_operation_i == OP_TICK))
    |=> (tick_q == $past(tick_q) + TICK_W'(1)))
    else $error("tick total not advanced on tick item");

  a_sweep_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sweep && rd_pend_q) |-> (CntW'(rd_idx_q) < n_q))
    else $error("countdown sweep beyond slots in use");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/thread_scheduler_with_sleep_timers_top.sv @@
`default_nettype none
// A tick item sweeps the countdowns of the n slots in use ahead of the search, while a
// sleep item skips the sweep; the search start slot comes from repeated subtraction of n-1;
// the countdown sweep and the round robin search each walk the slot memory through its
// single read port.
// Throughput: one item in flight; the next item is taken while a result waits, then
// holds at its pick step until that result is taken.
// Reset (async, active low): slot 0 running, others ready, counts zero, thread_count 1.

module thread_scheduler_with_sleep_timers_top import ts_pkg::*; #(
  parameter int MaxThreads = TS_MAX_THREADS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  ts_req_if.sink           req_i,
  ts_rsp_if.source         rsp_o
);

  ts_cmd_t cmd;
  ts_sts_t sts;

  // controller
  ts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  ts_dpath #(
    .MaxThreads (MaxThreads)
  ) u_dpath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_operation_i         (req_i.operation),
    .in_sleep_ticks_i       (req_i.sleep_ticks),
    .out_ready_i            (rsp_o.ready),
    .out_valid_o            (rsp_o.valid),
    .out_running_thread_o   (rsp_o.running_thread),
    .out_previous_thread_o  (rsp_o.previous_thread),
    .out_switched_o         (rsp_o.switched),
    .out_picks_of_running_o (rsp_o.picks_of_running),
    .out_ticks_seen_o       (rsp_o.ticks_seen),
    .cmd_i                  (cmd),
    .sts_o                  (sts)
  );

endmodule

`default_nettype wire

@@ tb/thread_scheduler_with_sleep_timers_top_tb.sv @@
`default_nettype none

module thread_scheduler_with_sleep_timers_top_tb import ts_pkg::*; ();

  localparam int Slots = TS_MAX_THREADS;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned MaxReports = 30;

  typedef struct packed {
    logic [THREAD_W-1:0] running;
    logic [THREAD_W-1:0] previous;
    logic                switched;
    logic [PICK_W-1:0]   picks;
    logic [TICK_W-1:0]   ticks;
  } sched_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  ts_req_if req_if ();
  ts_rsp_if rsp_if ();

  thread_scheduler_with_sleep_timers_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if.sink),
    .rsp_o       (rsp_if.source)
  );

  // scheduler shadow state
  status_e            slot_state [Slots];
  logic [SLEEP_W-1:0] slot_sleep [Slots];
  logic [PICK_W-1:0]  slot_picks [Slots];
  int unsigned        cur_slot;
  logic [TICK_W-1:0]  tick_total;
  logic [CFG_W-1:0]   cfg_count;

  sched_result_t sched_result_q [$];

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_left;
  bit          hold_req;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void reset_shadow();
    for (int unsigned i = 0; i < Slots; i++) begin
      slot_state[i] = ST_READY;
      slot_sleep[i] = '0;
      slot_picks[i] = '0;
    end
    slot_state[0] = ST_RUNNING;
    cur_slot      = 0;
    tick_total    = '0;
    cfg_count     = CFG_W'(1);
  endfunction

  // round robin over slots 1..n-1 starting after the current slot, idle slot as fallback
  function automatic int unsigned next_ready(input int unsigned n);
    int unsigned span;
    int unsigned id;
    if (n < 2) return 0;
    span = n - 1;
    for (int unsigned k = 0; k < span; k++) begin
      id = 1 + (cur_slot + k) % span;
      if (slot_state[id] == ST_READY) return id;
    end
    return 0;
  endfunction

  // advance the shadow scheduler by one item and return the schedule decision
  function automatic sched_result_t schedule_item(input logic op,
                                                  input logic [SLEEP_W-1:0] ticks);
    sched_result_t res;
    int unsigned   n;
    int unsigned   old;
    int unsigned   nxt;
    n = cfg_count;
    if (n < 1) n = 1;
    if (n > Slots) n = Slots;
    old = cur_slot;
    if (op == OP_TICK) begin
      tick_total++;
      // only slots in use count down
      for (int unsigned i = 0; i < n; i++) begin
        if (slot_state[i] == ST_SLEEPING) begin
          slot_sleep[i]--;
          if (slot_sleep[i] == '0) slot_state[i] = ST_READY;
        end
      end
      slot_state[old] = ST_READY;
      nxt = next_ready(n);
      slot_state[nxt] = ST_RUNNING;
      slot_picks[nxt]++;
    end else begin
      slot_state[old] = ST_SLEEPING;
      slot_sleep[old] = ticks;
      nxt = next_ready(n);
      slot_state[nxt] = ST_RUNNING;
    end
    cur_slot = nxt;
    res.running  = nxt[THREAD_W-1:0];
    res.previous = old[THREAD_W-1:0];
    res.switched = (nxt != old);
    res.picks    = slot_picks[nxt];
    res.ticks    = tick_total;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MaxReports)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : rsp_check
    sched_result_t got;
    sched_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.running_thread, rsp_if.previous_thread, rsp_if.switched,
              rsp_if.picks_of_running, rsp_if.ticks_seen};
      if (sched_result_q.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("%0t: unexpected item, expected none, actual %0h", $time, got);
      end else begin
        want = sched_result_q.pop_front();
        check_field("running_thread", 32'(want.running), 32'(got.running));
        check_field("previous_thread", 32'(want.previous), 32'(got.previous));
        check_field("switched", 32'(want.switched), 32'(got.switched));
        check_field("picks_of_running", 32'(want.picks), 32'(got.picks));
        check_field("ticks_seen", want.ticks, got.ticks);
      end
    end
  end

  // receiver ready: long hold-off on request, otherwise random stalls
  always @(posedge clk_i) begin : rsp_ready
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // offer one item, with random idle cycles ahead of it
  task automatic send_item(input logic op, input logic [SLEEP_W-1:0] ticks);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      req_if.valid       <= 1'b0;
      req_if.operation   <= 1'($urandom_range(0, 1));
      req_if.sleep_ticks <= SLEEP_W'($urandom_range(0, 65535));
      @(posedge clk_i);
      while ($urandom_range(0, 99) < snd_idle_pct) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.sleep_ticks <= ticks;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sched_result_q.push_back(schedule_item(op, ticks));
  endtask

  task automatic send_tick();
    send_item(OP_TICK, SLEEP_W'($urandom_range(0, 65535)));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (sched_result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_thread_count(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cfg_count = value;
  endtask

  function automatic logic [CFG_W-1:0] random_thread_count();
    case ($urandom_range(0, 11))
      0:       return CFG_W'(0);
      1:       return CFG_W'(15);
      2:       return CFG_W'(1);
      3:       return CFG_W'(2);
      4, 5:    return CFG_W'(8);
      6:       return CFG_W'($urandom_range(9, 15));
      default: return CFG_W'($urandom_range(3, 8));
    endcase
  endfunction

  // only the idle thread: ticks and sleeps with extreme counts, zero meaning the full wrap
  task automatic test_idle_thread();
    send_tick();
    send_item(OP_SLEEP, 16'h0000);
    send_item(OP_SLEEP, 16'hFFFF);
    send_tick();
    send_item(OP_SLEEP, 16'h5555);
  endtask

  // out of range counts clamp to one and to the slot limit
  task automatic test_count_clamp();
    write_thread_count(4'd0);
    send_tick();
    write_thread_count(4'd15);
    repeat (3) send_tick();
  endtask

  // threads sleep, idle thread takes over, threads wake on countdown
  task automatic test_sleep_wake();
    write_thread_count(4'd3);
    send_tick();
    send_item(OP_SLEEP, 16'd3);
    send_item(OP_SLEEP, 16'd1);
    repeat (3) send_tick();
  endtask

  // count lowered below the running slot while a slot beyond it sleeps
  task automatic test_count_lowered();
    write_thread_count(4'd8);
    for (int k = 0; k < 8 && cur_slot != 6; k++) send_tick();
    send_item(OP_SLEEP, 16'd5);
    write_thread_count(4'd3);
    repeat (3) send_tick();
    write_thread_count(4'd8);
    repeat (4) send_tick();
  endtask

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned items);
    logic               op;
    logic [SLEEP_W-1:0] ticks;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int unsigned k = 0; k < items; k++) begin
      if (k % 32 == 0) write_thread_count(random_thread_count());
      op = ($urandom_range(0, 99) < 30) ? OP_SLEEP : OP_TICK;
      // the idle thread may sleep any length, others mostly short so they come back
      if (op == OP_TICK || cur_slot == 0) ticks = SLEEP_W'($urandom_range(0, 65535));
      else if ($urandom_range(0, 99) < 97) ticks = SLEEP_W'($urandom_range(1, 12));
      else ticks = SLEEP_W'($urandom_range(13, 400));
      send_item(op, ticks);
    end
  endtask

  // receiver stops for a long stretch while items keep coming
  task automatic test_output_backpressure();
    write_thread_count(4'd6);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req     = 1'b1;
    for (int k = 0; k < 12; k++) begin
      if ($urandom_range(0, 3) == 0 && cur_slot != 0)
        send_item(OP_SLEEP, SLEEP_W'($urandom_range(1, 6)));
      else
        send_tick();
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.operation   = OP_TICK;
    req_if.sleep_ticks = '0;
    rsp_if.ready       = 1'b0;
    err_count          = 0;
    cycle_count        = 0;
    hold_left          = 0;
    hold_req           = 1'b0;
    snd_idle_pct       = 10;
    rcv_idle_pct       = 25;
    reset_shadow();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_thread();
    test_count_clamp();
    test_sleep_wake();
    test_count_lowered();
    test_random_traffic(16, 50, 133);
    test_random_traffic(50, 16, 133);
    test_random_traffic(0, 0, 134);
    test_output_backpressure();

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/ts_pkg.sv
hw/rtl/ts_intf.sv
hw/rtl/ts_ctrl.sv
hw/rtl/ts_dpath.sv
hw/rtl/thread_scheduler_with_sleep_timers_top.sv
tb/thread_scheduler_with_sleep_timers_top_tb.sv
